FILE: rtl/cctl_pkg.sv
// Shared types and fixed coefficients for the colour temperature and lux pipeline.
`default_nettype none
package cctl_pkg;

  // Widths of the front-end sums
  localparam int PW = 48;  // P and D, signed
  localparam int AW = 47;  // |P| and |D|
  localparam int YW = 36;  // Y scaled by 1e5, signed
  localparam int SW = 38;  // X+Y+Z scaled by 1e5, signed

  // P = 10000 X - 3320 S, per channel
  localparam int P_R = 238814000;
  localparam int P_G = 254991120;
  localparam int P_B = -582910000;
  // D = 1858 S - 10000 Y, per channel
  localparam int D_R = 111082900;
  localparam int D_G = -854058428;
  localparam int D_B = 522885000;
  // Y row, scaled by 1e5
  localparam int Y_R = -32466;
  localparam int Y_G = 157837;
  localparam int Y_B = -73191;
  // X+Y+Z, scaled by 1e5
  localparam int S_R = -114950;
  localparam int S_G = 389834;
  localparam int S_B = -112500;

  // Divide by 1e5 for values below 2^32: (a * LUX_RECIP) >> LUX_SHIFT
  localparam logic [32:0] LUX_RECIP = 33'd5629499535;
  localparam int          LUX_SHIFT = 49;
  // Divide by 100 for values below 2^22: (a * CCT_RECIP) >> CCT_SHIFT
  localparam logic [22:0] CCT_RECIP = 23'd5368710;
  localparam int          CCT_SHIFT = 29;

  // Cubic coefficients scaled by 100
  localparam int C3 = 44900;
  localparam int C2 = 352500;
  localparam int C1 = 682330;
  localparam int C0 = 552033;

  typedef struct packed {
    logic        degen;
    logic        neg;
    logic [15:0] lux;
  } side_t;

endpackage
`default_nettype wire

FILE: rtl/cctl_front.sv
// Matrix stage: P, D and Y from raw RGB, magnitudes, clamp test and saturated lux.
`default_nettype none
module cctl_front import cctl_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [15:0]   red_i,
  input  logic [15:0]   green_i,
  input  logic [15:0]   blue_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [AW-1:0] ap_o,
  output logic [AW-1:0] ad_o,
  output logic          clamp_o,
  output side_t         side_o
);

  logic en_a, en_b, en_c;
  logic va_q, vb_q, vc_q;

  // stage A
  logic signed [PW-1:0] r_p, g_p, b_p;
  logic signed [YW-1:0] r_y, g_y, b_y;
  logic signed [SW-1:0] r_s, g_s, b_s;
  logic signed [PW-1:0] p_d, d_d, p_q, d_q;
  logic signed [YW-1:0] y_d, y_q;
  logic signed [SW-1:0] s_sum;
  logic                 szero_q;

  // stage B
  logic [PW-1:0] pmag, dmag;
  logic [YW-1:0] ymag;
  logic [AW-1:0] apb_q, adb_q;
  logic          clampb_q, degenb_q, negb_q, ybig_q, yneg_q;
  logic [64:0]   lprod_d, lprod_q;

  // stage C
  logic [15:0]   lq, lux_d;
  logic [AW-1:0] apc_q, adc_q;
  logic          clampc_q;
  side_t         sidec_q;

  assign en_c = !vc_q || out_ready_i;
  assign en_b = !vb_q || en_c;
  assign en_a = !va_q || en_b;
  assign in_ready_o = en_a;

  assign r_p = PW'($signed({1'b0, red_i}));
  assign g_p = PW'($signed({1'b0, green_i}));
  assign b_p = PW'($signed({1'b0, blue_i}));
  assign r_y = YW'($signed({1'b0, red_i}));
  assign g_y = YW'($signed({1'b0, green_i}));
  assign b_y = YW'($signed({1'b0, blue_i}));
  assign r_s = SW'($signed({1'b0, red_i}));
  assign g_s = SW'($signed({1'b0, green_i}));
  assign b_s = SW'($signed({1'b0, blue_i}));

  assign p_d   = r_p * PW'(P_R) + g_p * PW'(P_G) + b_p * PW'(P_B);
  assign d_d   = r_p * PW'(D_R) + g_p * PW'(D_G) + b_p * PW'(D_B);
  assign y_d   = r_y * YW'(Y_R) + g_y * YW'(Y_G) + b_y * YW'(Y_B);
  assign s_sum = r_s * SW'(S_R) + g_s * SW'(S_G) + b_s * SW'(S_B);

  assign pmag = p_q[PW-1] ? PW'(-p_q) : PW'(p_q);
  assign dmag = d_q[PW-1] ? PW'(-d_q) : PW'(d_q);
  assign ymag = y_q[YW-1] ? YW'(-y_q) : YW'(y_q);
  assign lprod_d = 65'(ymag[31:0]) * 65'(LUX_RECIP);

  assign lq = lprod_q[LUX_SHIFT +: 16];
  always_comb begin
    if (!yneg_q) begin
      lux_d = (ybig_q || lq > 16'd32767) ? 16'h7fff : lq;
    end else begin
      lux_d = (ybig_q || lq > 16'd32768) ? 16'h8000 : 16'(-lq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      p_q     <= p_d;
      d_q     <= d_d;
      y_q     <= y_d;
      szero_q <= (s_sum == '0);
    end
    if (en_b) begin
      apb_q    <= pmag[AW-1:0];
      adb_q    <= dmag[AW-1:0];
      clampb_q <= {4'b0, pmag[AW-1:0]} >= {dmag[AW-1:0], 4'b0};
      degenb_q <= szero_q || (d_q == '0);
      negb_q   <= p_q[PW-1] ^ d_q[PW-1];
      ybig_q   <= |ymag[YW-1:32];
      yneg_q   <= y_q[YW-1];
      lprod_q  <= lprod_d;
    end
    if (en_c) begin
      apc_q       <= apb_q;
      adc_q       <= adb_q;
      clampc_q    <= clampb_q;
      sidec_q.degen <= degenb_q;
      sidec_q.neg   <= negb_q;
      sidec_q.lux   <= lux_d;
    end
  end

  assign out_valid_o = vc_q;
  assign ap_o    = apc_q;
  assign ad_o    = adc_q;
  assign clamp_o = clampc_q;
  assign side_o  = sidec_q;

endmodule
`default_nettype wire

FILE: rtl/cctl_div.sv
// Pipelined restoring divider: |n| = floor(|P| * 2^FRAC_BITS / |D|), one quotient bit a stage.
`default_nettype none
module cctl_div import cctl_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [AW-1:0]        ap_i,
  input  logic [AW-1:0]        ad_i,
  input  logic                 clamp_i,
  input  side_t                side_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [FRAC_BITS+4:0] mag_o,
  output side_t                side_o
);

  localparam int NSTEP = FRAC_BITS + 4;
  localparam int RW    = AW + 4;

  logic [NSTEP-1:0] v_q;
  logic [NSTEP:0]   en;
  logic [RW-1:0]    r_q  [NSTEP];
  logic [RW-1:0]    dd_q [NSTEP];
  logic [NSTEP-1:0] qt_q [NSTEP];
  logic             cl_q [NSTEP];
  side_t            sd_q [NSTEP];

  assign en[NSTEP]  = out_ready_i;
  assign in_ready_o = en[0];

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic             v_in, cl_in, ge;
    logic [RW-1:0]    r_in, dd_in, r_d;
    logic [NSTEP-1:0] q_in;
    side_t            sd_in;
    logic [RW:0]      dbl, diff;

    if (k == 0) begin : g_first
      assign v_in  = in_valid_i;
      assign r_in  = RW'(ap_i);
      assign dd_in = {ad_i, 4'b0};
      assign q_in  = '0;
      assign cl_in = clamp_i;
      assign sd_in = side_i;
    end else begin : g_next
      assign v_in  = v_q[k-1];
      assign r_in  = r_q[k-1];
      assign dd_in = dd_q[k-1];
      assign q_in  = qt_q[k-1];
      assign cl_in = cl_q[k-1];
      assign sd_in = sd_q[k-1];
    end

    // double the remainder, subtract the divisor where it fits
    assign dbl  = {r_in, 1'b0};
    assign ge   = dbl >= {1'b0, dd_in};
    assign diff = dbl - {1'b0, dd_in};
    assign r_d  = ge ? diff[RW-1:0] : dbl[RW-1:0];

    assign en[k] = !v_q[k] || en[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        r_q[k]  <= r_d;
        dd_q[k] <= dd_in;
        qt_q[k] <= {q_in[NSTEP-2:0], ge};
        cl_q[k] <= cl_in;
        sd_q[k] <= sd_in;
      end
    end
  end

  assign out_valid_o = v_q[NSTEP-1];
  assign mag_o  = cl_q[NSTEP-1] ? {1'b1, {NSTEP{1'b0}}} : {1'b0, qt_q[NSTEP-1]};
  assign side_o = sd_q[NSTEP-1];

endmodule
`default_nettype wire

FILE: rtl/cctl_poly.sv
// Cubic stage: n^2, n^3, weighted sum, scale by 1/100 and saturate.
`default_nettype none
module cctl_poly import cctl_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [FRAC_BITS+4:0] mag_i,
  input  side_t                side_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [15:0]          cct_o,
  output logic [15:0]          lux_o,
  output logic                 degen_o
);

  localparam int MW  = FRAC_BITS + 5;
  localparam int M2W = 2 * MW;
  localparam int N2W = FRAC_BITS + 9;
  localparam int P3W = N2W + MW;
  localparam int N3W = FRAC_BITS + 13;
  localparam int TW  = FRAC_BITS + 30;
  localparam int AMW = TW - FRAC_BITS;

  logic en1, en2, en3, en4, en5;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  logic [MW-1:0]  m1_q, m2m_q;
  logic [M2W-1:0] sq_q;
  side_t          sd1_q, sd2_q, sd3_q, sd4_q;

  logic [N2W-1:0] n2_d, n2_q;
  logic [P3W-1:0] p3_q;

  logic [N3W-1:0]       n3;
  logic [TW-1:0]        n3_e, n1_e;
  logic signed [TW-1:0] n3_s, n1_s, t3_q, t12_q, t_sum;
  logic [TW-1:0]        tmag;
  logic [AMW-1:0]       amag;
  logic [21:0]          alo_q;
  logic                 abig_q, tneg_q;

  logic [44:0] cprod;
  logic [15:0] cq, cct_d;
  logic [15:0] cct_q, lux_q;
  logic        degen_q;

  assign en5 = !v5_q || out_ready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  assign n2_d = sq_q[FRAC_BITS +: N2W];
  assign n3   = p3_q[FRAC_BITS +: N3W];
  assign n3_e = TW'(n3);
  assign n1_e = TW'(m2m_q);
  assign n3_s = sd2_q.neg ? $signed(-n3_e) : $signed(n3_e);
  assign n1_s = sd2_q.neg ? $signed(-n1_e) : $signed(n1_e);

  assign t_sum = t3_q + t12_q;
  assign tmag  = t_sum[TW-1] ? TW'(-t_sum) : TW'(t_sum);
  assign amag  = tmag[TW-1:FRAC_BITS];

  assign cprod = 45'(alo_q) * 45'(CCT_RECIP);
  assign cq    = cprod[CCT_SHIFT +: 16];
  always_comb begin
    if (sd4_q.degen) begin
      cct_d = '0;
    end else if (!tneg_q) begin
      cct_d = (abig_q || cq > 16'd32767) ? 16'h7fff : cq;
    end else begin
      cct_d = (abig_q || cq > 16'd32768) ? 16'h8000 : 16'(-cq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      m1_q  <= mag_i;
      sq_q  <= M2W'(mag_i) * M2W'(mag_i);
      sd1_q <= side_i;
    end
    if (en2) begin
      m2m_q <= m1_q;
      n2_q  <= n2_d;
      p3_q  <= P3W'(n2_d) * P3W'(m1_q);
      sd2_q <= sd1_q;
    end
    if (en3) begin
      t3_q  <= n3_s * $signed(TW'(C3));
      t12_q <= $signed(TW'(n2_q)) * $signed(TW'(C2)) + n1_s * $signed(TW'(C1))
             + ($signed(TW'(C0)) <<< FRAC_BITS);
      sd3_q <= sd2_q;
    end
    if (en4) begin
      alo_q  <= amag[21:0];
      abig_q <= |amag[AMW-1:22];
      tneg_q <= t_sum[TW-1];
      sd4_q  <= sd3_q;
    end
    if (en5) begin
      cct_q   <= cct_d;
      lux_q   <= sd4_q.lux;
      degen_q <= sd4_q.degen;
    end
  end

  assign out_valid_o = v5_q;
  assign cct_o   = cct_q;
  assign lux_o   = lux_q;
  assign degen_o = degen_q;

endmodule
`default_nettype wire

FILE: rtl/rgb_color_temperature_and_lux_top.sv
// Throughput: one word per cycle unless the output stalls; three matrix stages,
// FRAC_BITS + 4 divider stages (one quotient bit each) and five cubic stages, all
// with their own valid bits.
// A stalled output holds its word; upstream stages keep filling bubbles.
// Reset (rst_ni low, asynchronous) clears all valid bits; the block is stateless.
`default_nettype none
module rgb_color_temperature_and_lux_top import cctl_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // red [15:0], green [31:16], blue [47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // cct_kelvin [15:0], illuminance [31:16]
  output logic        m_axis_tuser    // degenerate
);

  logic                 f_valid, f_ready, f_clamp;
  logic [AW-1:0]        f_ap, f_ad;
  side_t                f_side;
  logic                 d_valid, d_ready;
  logic [FRAC_BITS+4:0] d_mag;
  side_t                d_side;
  logic [15:0]          cct, lux;

  cctl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .red_i       (s_axis_tdata[15:0]),
    .green_i     (s_axis_tdata[31:16]),
    .blue_i      (s_axis_tdata[47:32]),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .ap_o        (f_ap),
    .ad_o        (f_ad),
    .clamp_o     (f_clamp),
    .side_o      (f_side)
  );

  cctl_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .ap_i        (f_ap),
    .ad_i        (f_ad),
    .clamp_i     (f_clamp),
    .side_i      (f_side),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .mag_o       (d_mag),
    .side_o      (d_side)
  );

  cctl_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d_valid),
    .in_ready_o  (d_ready),
    .mag_i       (d_mag),
    .side_i      (d_side),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cct_o       (cct),
    .lux_o       (lux),
    .degen_o     (m_axis_tuser)
  );

  assign m_axis_tdata = {lux, cct};

endmodule
`default_nettype wire
